/* hw/rtl/uer_pkg.sv */
// Package for the echo ranger: types, constants and the sequencer microcode.
`timescale 1ns / 1ps
package uer_pkg;

	localparam int SAMPLES   = 3;
	localparam int TOTAL_W   = 18;
	localparam int TICKS_W   = 17;
	localparam int DIST_W    = 12;
	localparam int DIV_STEPS = TOTAL_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_TRIG,
		PH_WAIT,
		PH_MEAS,
		PH_GAP
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BLIND,
		ST_NO_ECHO
	} status_t;

	typedef enum logic [2:0] {
		REG_PRE_LOW,
		REG_TRIGGER,
		REG_TIMEOUT,
		REG_MAX_VALID,
		REG_GAP,
		REG_BLIND,
		REG_US_PER_CM
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_DIV,
		OP_BLIND,
		OP_SAT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		S_ACCEPT,
		S_DIV_AVG,
		S_BLIND,
		S_DIV_DIST,
		S_SAT,
		S_EMIT
	} step_t;

	typedef struct packed {
		op_t   op;
		step_t next;
		step_t jump;
	} ctrl_t;

	// Microcode: next is taken when a step finishes, jump on the step's branch condition.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		begin
			case (s)
				S_ACCEPT:   w = '{op: OP_ACCEPT, next: S_DIV_AVG,  jump: S_EMIT};
				S_DIV_AVG:  w = '{op: OP_DIV,    next: S_BLIND,    jump: S_BLIND};
				S_BLIND:    w = '{op: OP_BLIND,  next: S_DIV_DIST, jump: S_EMIT};
				S_DIV_DIST: w = '{op: OP_DIV,    next: S_SAT,      jump: S_SAT};
				S_SAT:      w = '{op: OP_SAT,    next: S_EMIT,     jump: S_EMIT};
				S_EMIT:     w = '{op: OP_EMIT,   next: S_ACCEPT,   jump: S_ACCEPT};
				default:    w = '{op: OP_ACCEPT, next: S_ACCEPT,   jump: S_ACCEPT};
			endcase
			return w;
		end
	endfunction

endpackage

/* hw/rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger: per-tick trigger/echo timing and averaged distance result.
`timescale 1ns / 1ps
// One item is one microsecond tick; every item gives exactly one result item. A plain
// tick runs the accept step, then the emit step. The tick that closes a ranging with at
// least one valid echo runs a shared 18-step restoring divider twice, first for the
// average width, then for average / us_per_cm, driven by a six-step microcode program.
// When the average falls in the blind zone or us_per_cm is zero the second division is
// skipped. Items are taken while the last result still waits; the emit step holds only
// until the output register is free, so a stalled output adds its stall cycles to the
// tick. Configuration is written by cfg_we / cfg_index / cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce.
module ultrasonic_echo_ranger
	import uer_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_valid,
	output logic                tick_stall,
	input  logic                echo_level,
	input  logic                start_req,
	output logic                res_valid,
	input  logic                res_stall,
	output logic                trigger_level,
	output logic                busy_res,
	output logic                done_res,
	output logic [1:0]          status,
	output logic [DIST_W-1:0]   distance_cm,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata
);

	// configuration
	logic [7:0]  pre_low_q, trigger_q, us_per_cm_q;
	logic [15:0] timeout_q, max_valid_q, gap_q, blind_q;

	// ranging state
	phase_t              phase_q;
	logic [TICKS_W-1:0]  ticks_q;
	logic [1:0]          sample_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [1:0]          count_q;

	// sequencer and datapath
	step_t               step_q, step_next;
	ctrl_t               cw;
	logic [TOTAL_W-1:0]  quo_q;
	logic [7:0]          rem_q, dvs_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                wtrig_q, wbusy_q, wdone_q;
	status_t             wstatus_q;
	logic [DIST_W-1:0]   wdist_q;

	logic                out_valid_q, out_trig_q, out_busy_q, out_done_q;
	status_t             out_status_q;
	logic [DIST_W-1:0]   out_dist_q;

	// tick update
	phase_t              n_ph;
	logic [TICKS_W-1:0]  n_tk, end_w;
	logic [1:0]          n_sn, n_vc, div_vc;
	logic [TOTAL_W-1:0]  n_wt, div_wt;
	logic                used, end_s, t_trig, t_done, t_busy, need_div;
	status_t             t_st;

	logic                accept, out_free, div_last, branch;
	logic [8:0]          trial;
	logic                ge;

	assign cw         = ucode(step_q);
	assign tick_stall = (cw.op != OP_ACCEPT);
	assign accept     = tick_valid && !tick_stall;
	assign out_free   = !out_valid_q || !res_stall;
	assign div_last   = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign trial      = {rem_q, quo_q[TOTAL_W-1]};
	assign ge         = (trial >= {1'b0, dvs_q});

	always_comb begin
		n_ph     = phase_q;
		n_tk     = ticks_q;
		n_sn     = sample_q;
		n_wt     = total_q;
		n_vc     = count_q;
		div_wt   = total_q;
		div_vc   = count_q;
		used     = 1'b0;
		end_s    = 1'b0;
		end_w    = '0;
		t_trig   = 1'b0;
		t_done   = 1'b0;
		t_st     = ST_OK;
		need_div = 1'b0;

		if (n_ph == PH_IDLE) begin
			if (start_req) begin
				n_ph = PH_PRE;
				n_tk = '0;
				n_sn = '0;
				n_wt = '0;
				n_vc = '0;
			end
			used = 1'b1;
		end
		if (!used && n_ph == PH_GAP) begin
			if (n_tk >= {1'b0, gap_q}) begin
				n_sn = n_sn + 2'd1;
				if (n_sn >= 2'(SAMPLES)) begin
					t_done = 1'b1;
					div_wt = n_wt;
					div_vc = n_vc;
					if (n_vc == 2'd0)
						t_st = ST_NO_ECHO;
					else
						need_div = 1'b1;
					n_ph = PH_IDLE;
					n_tk = '0;
					n_sn = '0;
					n_wt = '0;
					n_vc = '0;
					used = 1'b1;
				end else begin
					n_ph = PH_PRE;
					n_tk = '0;
				end
			end else begin
				n_tk = n_tk + 1'b1;
				used = 1'b1;
			end
		end
		if (!used && n_ph == PH_PRE) begin
			if (n_tk >= {9'd0, pre_low_q}) begin
				n_ph = PH_TRIG;
				n_tk = '0;
			end else begin
				n_tk = n_tk + 1'b1;
				used = 1'b1;
			end
		end
		if (!used && n_ph == PH_TRIG) begin
			if (n_tk >= {9'd0, trigger_q}) begin
				n_ph = PH_WAIT;
				n_tk = '0;
			end else begin
				t_trig = 1'b1;
				n_tk   = n_tk + 1'b1;
				used   = 1'b1;
			end
		end
		if (!used && n_ph == PH_WAIT) begin
			if (echo_level) begin
				n_ph = PH_MEAS;
				n_tk = '0;
			end else begin
				n_tk = n_tk + 1'b1;
				if (n_tk > {1'b0, timeout_q})
					end_s = 1'b1;
				used = 1'b1;
			end
		end
		if (!used && n_ph == PH_MEAS) begin
			if (echo_level) begin
				n_tk = n_tk + 1'b1;
				if (n_tk > {1'b0, timeout_q})
					end_s = 1'b1;
			end else begin
				end_s = 1'b1;
				end_w = n_tk;
			end
			used = 1'b1;
		end
		if (end_s) begin
			if (end_w != '0 && end_w <= {1'b0, max_valid_q}) begin
				n_wt = n_wt + TOTAL_W'(end_w);
				n_vc = n_vc + 2'd1;
			end
			n_ph = PH_GAP;
			n_tk = '0;
		end
		t_busy = (n_ph != PH_IDLE) || t_done;
	end

	// branch condition of the current step
	always_comb begin
		case (cw.op)
			OP_ACCEPT: branch = !need_div;
			OP_BLIND:  branch = (quo_q < {2'b00, blind_q}) || (us_per_cm_q == 8'd0);
			default:   branch = 1'b0;
		endcase
	end

	always_comb begin
		step_next = step_q;
		case (cw.op)
			OP_ACCEPT: if (accept) step_next = branch ? cw.jump : cw.next;
			OP_DIV:    if (div_last) step_next = cw.next;
			OP_BLIND:  step_next = branch ? cw.jump : cw.next;
			OP_SAT:    step_next = cw.next;
			OP_EMIT:   if (out_free) step_next = cw.next;
			default:   step_next = S_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_ACCEPT;
		end else begin
			step_q <= step_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_low_q   <= 8'd5;
			trigger_q   <= 8'd10;
			timeout_q   <= 16'd38000;
			max_valid_q <= 16'd23200;
			gap_q       <= 16'd15000;
			blind_q     <= 16'd116;
			us_per_cm_q <= 8'd58;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PRE_LOW:   pre_low_q   <= cfg_wdata[7:0];
				REG_TRIGGER:   trigger_q   <= cfg_wdata[7:0];
				REG_TIMEOUT:   timeout_q   <= cfg_wdata;
				REG_MAX_VALID: max_valid_q <= cfg_wdata;
				REG_GAP:       gap_q       <= cfg_wdata;
				REG_BLIND:     blind_q     <= cfg_wdata;
				REG_US_PER_CM: us_per_cm_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ticks_q  <= '0;
			sample_q <= '0;
			total_q  <= '0;
			count_q  <= '0;
		end else if (accept) begin
			phase_q  <= n_ph;
			ticks_q  <= n_tk;
			sample_q <= n_sn;
			total_q  <= n_wt;
			count_q  <= n_vc;
		end
	end

	// working result and shared divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cw.op)
				OP_DIV:  cnt_q <= div_last ? '0 : cnt_q + 1'b1;
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_ACCEPT: begin
				if (accept) begin
					wtrig_q   <= t_trig;
					wbusy_q   <= t_busy;
					wdone_q   <= t_done;
					wstatus_q <= t_st;
					wdist_q   <= '0;
					quo_q     <= div_wt;
					rem_q     <= '0;
					dvs_q     <= {6'd0, div_vc};
				end
			end
			OP_DIV: begin
				quo_q <= {quo_q[TOTAL_W-2:0], ge};
				rem_q <= ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
			end
			OP_BLIND: begin
				if (quo_q < {2'b00, blind_q}) begin
					wstatus_q <= ST_BLIND;
				end else if (us_per_cm_q == 8'd0) begin
					wdist_q <= '1;
				end
				rem_q <= '0;
				dvs_q <= us_per_cm_q;
			end
			OP_SAT: begin
				wdist_q <= (|quo_q[TOTAL_W-1:DIST_W]) ? '1 : quo_q[DIST_W-1:0];
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT && out_free) begin
			out_trig_q   <= wtrig_q;
			out_busy_q   <= wbusy_q;
			out_done_q   <= wdone_q;
			out_status_q <= wstatus_q;
			out_dist_q   <= wdist_q;
		end
	end

	assign res_valid     = out_valid_q;
	assign trigger_level = out_trig_q;
	assign busy_res      = out_busy_q;
	assign done_res      = out_done_q;
	assign status        = out_status_q;
	assign distance_cm   = out_dist_q;

endmodule

/* test/ultrasonic_echo_ranger_test.sv */
// Self-checking testbench for the ultrasonic echo ranger: directed and random tick items.
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_test;
	import uer_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic              trig;
		logic              busy;
		logic              done;
		status_t           st;
		logic [DIST_W-1:0] dist_cm;
	} tick_res_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              tick_valid = 1'b0;
	logic              tick_stall;
	logic              echo_level = 1'b0;
	logic              start_req = 1'b0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic              trigger_level;
	logic              busy_res;
	logic              done_res;
	logic [1:0]        status;
	logic [DIST_W-1:0] distance_cm;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [15:0]       cfg_wdata = '0;

	// register copies, reset values
	logic [7:0]  cfg_pre = 8'd5;
	logic [7:0]  cfg_trig = 8'd10;
	logic [15:0] cfg_timeout = 16'd38000;
	logic [15:0] cfg_maxv = 16'd23200;
	logic [15:0] cfg_gap = 16'd15000;
	logic [15:0] cfg_blind = 16'd116;
	logic [7:0]  cfg_upc = 8'd58;

	// ranging state as the block should hold it
	phase_t      rng_phase = PH_IDLE;
	logic [16:0] rng_ticks = '0;
	logic [1:0]  rng_sample = '0;
	logic [17:0] rng_total = '0;
	logic [1:0]  rng_valid = '0;

	tick_res_t pending_res[$];
	int        bad_results = 0;
	int        ticks_sent = 0;
	int        quiet_cycles = 0;
	logic      idle_on = 1'b1;
	logic      plan_fixed = 1'b0;
	int        plan_delay = 0;
	int        plan_width = 1;

	ultrasonic_echo_ranger u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick_valid    (tick_valid),
		.tick_stall    (tick_stall),
		.echo_level    (echo_level),
		.start_req     (start_req),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.trigger_level (trigger_level),
		.busy_res      (busy_res),
		.done_res      (done_res),
		.status        (status),
		.distance_cm   (distance_cm),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void close_reading(input logic [16:0] width);
		if (width != 0 && width <= cfg_maxv) begin
			rng_total = rng_total + width;
			rng_valid = rng_valid + 1'b1;
		end
		rng_phase = PH_GAP;
		rng_ticks = '0;
	endfunction

	// Advances the ranging state by one tick and returns the result item it gives.
	function automatic tick_res_t ranger_tick(input logic echo, input logic start);
		tick_res_t   r;
		logic        used;
		logic [17:0] avg;
		logic [17:0] quot;
		r = '0;
		used = 1'b0;
		if (rng_phase == PH_IDLE) begin
			if (start) begin
				rng_phase = PH_PRE;
				rng_ticks = '0;
				rng_sample = '0;
				rng_total = '0;
				rng_valid = '0;
			end
			used = 1'b1;
		end
		if (!used && rng_phase == PH_GAP) begin
			if (rng_ticks >= cfg_gap) begin
				rng_sample = rng_sample + 1'b1;
				if (rng_sample >= SAMPLES) begin
					r.done = 1'b1;
					if (rng_valid == 0) begin
						r.st = ST_NO_ECHO;
					end else begin
						avg = rng_total / rng_valid;
						if (avg < cfg_blind) begin
							r.st = ST_BLIND;
						end else if (cfg_upc == 0) begin
							r.dist_cm = '1;
						end else begin
							quot = avg / cfg_upc;
							r.dist_cm = (quot > 18'd4095) ? 12'd4095 : quot[DIST_W-1:0];
						end
					end
					rng_phase = PH_IDLE;
					rng_ticks = '0;
					rng_sample = '0;
					rng_total = '0;
					rng_valid = '0;
					used = 1'b1;
				end else begin
					rng_phase = PH_PRE;
					rng_ticks = '0;
				end
			end else begin
				rng_ticks = rng_ticks + 1'b1;
				used = 1'b1;
			end
		end
		// zero-length pre-low and trigger phases fall through within the tick
		if (!used && rng_phase == PH_PRE) begin
			if (rng_ticks >= cfg_pre) begin
				rng_phase = PH_TRIG;
				rng_ticks = '0;
			end else begin
				rng_ticks = rng_ticks + 1'b1;
				used = 1'b1;
			end
		end
		if (!used && rng_phase == PH_TRIG) begin
			if (rng_ticks >= cfg_trig) begin
				rng_phase = PH_WAIT;
				rng_ticks = '0;
			end else begin
				r.trig = 1'b1;
				rng_ticks = rng_ticks + 1'b1;
				used = 1'b1;
			end
		end
		if (!used && rng_phase == PH_WAIT) begin
			if (echo) begin
				rng_phase = PH_MEAS;
				rng_ticks = '0;
			end else begin
				rng_ticks = rng_ticks + 1'b1;
				if (rng_ticks > cfg_timeout)
					close_reading('0);
				used = 1'b1;
			end
		end
		if (!used && rng_phase == PH_MEAS) begin
			if (echo) begin
				rng_ticks = rng_ticks + 1'b1;
				if (rng_ticks > cfg_timeout)
					close_reading('0);
			end else begin
				close_reading(rng_ticks);
			end
		end
		r.busy = (rng_phase != PH_IDLE) || r.done;
		return r;
	endfunction

	// New echo delay and width for one sub-reading, biased toward the limits.
	function automatic void new_plan();
		int lt;
		int mv;
		int pick;
		logic short_to;
		lt = cfg_timeout;
		mv = cfg_maxv;
		short_to = (lt <= 60);
		pick = $urandom_range(0, 99);
		if (pick < 80)
			plan_delay = $urandom_range(0, (lt < 12) ? lt : 12);
		else if (short_to)
			plan_delay = lt + $urandom_range(0, 2);
		else
			plan_delay = $urandom_range(0, 30);
		pick = $urandom_range(0, 99);
		if (pick < 65)
			plan_width = $urandom_range(1, (mv < 40) ? mv : 40);
		else if (pick < 82 && mv <= 60)
			plan_width = mv + $urandom_range(0, 2);
		else if (short_to)
			plan_width = lt + $urandom_range(0, 2);
		else
			plan_width = $urandom_range(1, 60);
	endfunction

	function automatic logic pick_echo(input logic flip);
		logic e;
		if (rng_phase != PH_WAIT && rng_phase != PH_MEAS && !plan_fixed)
			new_plan();
		case (rng_phase)
			PH_WAIT: e = (rng_ticks >= plan_delay);
			PH_MEAS: e = (rng_ticks < plan_width);
			default: e = (plan_delay == 0);
		endcase
		if (flip && $urandom_range(0, 19) == 0)
			e = !e;
		return e;
	endfunction

	task automatic send_tick(input logic echo, input logic start);
		tick_res_t r;
		while (idle_on && $urandom_range(0, 99) < 34) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick_valid <= 1'b1;
		echo_level <= echo;
		start_req <= start;
		do
			@(posedge clk);
		while (tick_stall);
		r = ranger_tick(echo, start);
		pending_res.push_back(r);
		ticks_sent++;
	endtask

	task automatic quiesce();
		tick_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			REG_PRE_LOW:   cfg_pre = v[7:0];
			REG_TRIGGER:   cfg_trig = v[7:0];
			REG_TIMEOUT:   cfg_timeout = v;
			REG_MAX_VALID: cfg_maxv = v;
			REG_GAP:       cfg_gap = v;
			REG_BLIND:     cfg_blind = v;
			REG_US_PER_CM: cfg_upc = v[7:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [15:0] pre, input logic [15:0] trig,
			input logic [15:0] tmo, input logic [15:0] maxv, input logic [15:0] gap,
			input logic [15:0] blind, input logic [15:0] upc);
		quiesce();
		put_reg(REG_PRE_LOW, pre);
		put_reg(REG_TRIGGER, trig);
		put_reg(REG_TIMEOUT, tmo);
		put_reg(REG_MAX_VALID, maxv);
		put_reg(REG_GAP, gap);
		put_reg(REG_BLIND, blind);
		put_reg(REG_US_PER_CM, upc);
		cfg_we <= 1'b0;
	endtask

	// One start item, then ticks until the ranging has closed.
	task automatic run_ranging(input logic start_noise, input logic echo_noise);
		send_tick(1'($urandom_range(0, 1)), 1'b1);
		while (rng_phase != PH_IDLE)
			send_tick(pick_echo(echo_noise), start_noise && $urandom_range(0, 5) == 0);
	endtask

	task automatic fixed_ranging(input int delay, input int width, input logic start_noise);
		plan_fixed = 1'b1;
		plan_delay = delay;
		plan_width = width;
		run_ranging(start_noise, 1'b0);
		plan_fixed = 1'b0;
	endtask

	// Start a ranging, run the first sub-reading and one gap tick, then drain.
	task automatic ranging_to_gap();
		send_tick(1'($urandom_range(0, 1)), 1'b1);
		while (rng_phase != PH_GAP)
			send_tick(pick_echo(1'b0), 1'b0);
		send_tick(pick_echo(1'b0), 1'b0);
		quiesce();
	endtask

	task automatic finish_ranging();
		while (rng_phase != PH_IDLE)
			send_tick(pick_echo(1'b0), 1'b0);
	endtask

	// first sub-reading at reset values, then a short gap to keep the run brief
	task automatic test_reset_values();
		idle_on = 1'b0;
		plan_fixed = 1'b1;
		plan_delay = 2;
		plan_width = 120;
		ranging_to_gap();
		put_reg(REG_GAP, 16'd1);
		cfg_we <= 1'b0;
		finish_ranging();
		plan_fixed = 1'b0;
		idle_on = 1'b1;
	endtask

	task automatic test_phase_boundaries();
		// zero pre-low, trigger and gap; zero us_per_cm saturates
		load_config(0, 0, 20, 20, 0, 0, 0);
		fixed_ranging(0, 5, 1'b0);
		// echo start: one low tick too many, then exactly the limit
		load_config(1, 1, 3, 20, 1, 0, 2);
		fixed_ranging(4, 2, 1'b0);
		fixed_ranging(3, 2, 1'b0);
		// echo width just over and at the timeout
		load_config(2, 2, 5, 10, 1, 0, 1);
		fixed_ranging(1, 6, 1'b0);
		fixed_ranging(1, 5, 1'b0);
		// width just over and at the valid maximum
		load_config(1, 1, 10, 4, 0, 0, 1);
		fixed_ranging(0, 5, 1'b0);
		fixed_ranging(0, 4, 1'b0);
		// average just under and at the blind limit
		load_config(1, 1, 10, 10, 0, 6, 1);
		fixed_ranging(2, 5, 1'b0);
		fixed_ranging(2, 6, 1'b0);
	endtask

	task automatic test_start_while_busy();
		load_config(2, 2, 10, 10, 2, 0, 3);
		fixed_ranging(1, 7, 1'b1);
	endtask

	task automatic test_register_extremes();
		idle_on = 1'b0;
		load_config(255, 255, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 255);
		plan_fixed = 1'b1;
		plan_delay = 0;
		plan_width = 10;
		// first sub-reading at the largest lengths, the rest short
		ranging_to_gap();
		put_reg(REG_PRE_LOW, 16'd0);
		put_reg(REG_TRIGGER, 16'd1);
		put_reg(REG_GAP, 16'd0);
		cfg_we <= 1'b0;
		finish_ranging();
		plan_fixed = 1'b0;
		idle_on = 1'b1;
		load_config(0, 1, 1, 1, 0, 0, 16);
		fixed_ranging(1, 1, 1'b0);
	endtask

	task automatic random_config();
		logic [15:0] upc;
		case ($urandom_range(0, 3))
			0: upc = 16'd0;
			1: upc = 16'd1;
			2: upc = 16'($urandom_range(2, 16));
			default: upc = 16'd255;
		endcase
		load_config(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			16'($urandom_range(1, 30)),
			($urandom_range(0, 4) == 0) ? 16'hffff : 16'($urandom_range(1, 30)),
			16'($urandom_range(0, 3)), 16'($urandom_range(0, 20)), upc);
	endtask

	task automatic test_random();
		int n;
		n = 0;
		while (ticks_sent < 2000) begin
			if (n % 4 == 0)
				random_config();
			idle_on = !(n >= 10 && n < 16);
			// idle ticks; a stray start here opens a ranging that run_ranging finishes
			repeat ($urandom_range(0, 2))
				send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
			run_ranging(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
			n++;
		end
		idle_on = 1'b1;
	endtask

	always @(posedge clk) begin
		tick_res_t want;
		res_stall <= idle_on && ($urandom_range(0, 99) < 34);
		if (res_valid && !res_stall) begin
			if (pending_res.size() == 0) begin
				if (bad_results < 10)
					$display("unexpected result item: trig %0d busy %0d done %0d status %0d dist %0d",
						trigger_level, busy_res, done_res, status, distance_cm);
				bad_results++;
			end else begin
				want = pending_res.pop_front();
				if (want.trig !== trigger_level || want.busy !== busy_res ||
						want.done !== done_res || want.st !== status ||
						want.dist_cm !== distance_cm) begin
					if (bad_results < 10)
						$display("result mismatch: want %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
							want.trig, want.busy, want.done, want.st, want.dist_cm,
							trigger_level, busy_res, done_res, status, distance_cm);
					bad_results++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ultrasonic_echo_ranger regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_phase_boundaries();
		test_start_while_busy();
		test_register_extremes();
		test_random();
		quiesce();
		repeat (60) @(posedge clk);
		if (bad_results == 0 && pending_res.size() == 0)
			$display("ultrasonic_echo_ranger regression: pass");
		else
			$display("ultrasonic_echo_ranger regression: fail");
		$finish;
	end

endmodule
